// ===== hdl/api_pkg.sv =====
// Shared types and constants of the Ackermann pose integrator.
// Holds the sequencer state type, register indexes, fixed-point constants
// and the arctangent table; depends on nothing.
package api_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_M_DV,
      ST_D_DV,
      ST_M_DIST,
      ST_D_DIST,
      ST_M_BIAS,
      ST_D_BIAS,
      ST_M_BASE,
      ST_M_NB,
      ST_M_NA,
      ST_M_NAM,
      ST_M_BAM,
      ST_C_ARC,
      ST_D_X,
      ST_D_Y,
      ST_C_HEAD,
      ST_M_XA,
      ST_M_XB,
      ST_M_YA,
      ST_M_YB,
      ST_DONE
   } state_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 22;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SPEED     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CURVATURE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ACCEL     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGULAR_BIAS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGULAR_ERROR = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALE_AGE     = 3'd5;

   localparam logic [20:0] RST_MAX_SPEED     = 21'd131072;
   localparam logic [19:0] RST_MAX_CURVATURE = 20'd65536;
   localparam logic [21:0] RST_MAX_ACCEL     = 22'd327680;
   localparam logic [19:0] RST_STALE_AGE     = 20'd100000;

   localparam logic [19:0]        US_PER_S       = 20'd1000000;
   localparam logic signed [24:0] STOP_LIMIT     = 25'sd9831;
   localparam logic signed [20:0] STRAIGHT_LIMIT = 21'sd66;
   localparam logic [31:0]        RAD_TO_BAM     = 32'd683565276;
   localparam logic signed [33:0] GAIN_Q30       = 34'sd652032875;
   localparam logic signed [33:0] ONE_Q30        = 34'sd1073741824;
   localparam logic signed [33:0] HALF_TURN      = 34'sd2147483648;
   localparam logic signed [27:0] VEL_MAX        = 28'sd2097151;
   localparam logic signed [27:0] VEL_MIN        = -28'sd2097152;
   localparam logic signed [33:0] POS_MAX        = 34'sd2147483647;
   localparam logic signed [33:0] POS_MIN        = -34'sd2147483648;

   localparam int MUL_DIGIT = 4;
   localparam int MUL_STEPS = 8;
   localparam int DIV_BITS  = 44;

   function automatic logic signed [33:0] atan_lookup(input logic [4:0] idx);
      logic signed [33:0] r;
      case (idx)
         5'd0:  r = 34'sh020000000;
         5'd1:  r = 34'sh012E4051E;
         5'd2:  r = 34'sh009FB385B;
         5'd3:  r = 34'sh0051111D4;
         5'd4:  r = 34'sh0028B0D43;
         5'd5:  r = 34'sh00145D7E1;
         5'd6:  r = 34'sh000A2F61E;
         5'd7:  r = 34'sh000517C55;
         5'd8:  r = 34'sh00028BE53;
         5'd9:  r = 34'sh000145F2F;
         5'd10: r = 34'sh0000A2F98;
         5'd11: r = 34'sh0000517CC;
         5'd12: r = 34'sh000028BE6;
         5'd13: r = 34'sh0000145F3;
         5'd14: r = 34'sh00000A2FA;
         5'd15: r = 34'sh00000517D;
         5'd16: r = 34'sh0000028BE;
         5'd17: r = 34'sh00000145F;
         5'd18: r = 34'sh000000A30;
         5'd19: r = 34'sh000000518;
         5'd20: r = 34'sh00000028C;
         5'd21: r = 34'sh000000146;
         5'd22: r = 34'sh0000000A3;
         5'd23: r = 34'sh000000051;
         default: r = 34'sh000000000;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/ackermann_pose_integrator_unit.sv =====
// Ackermann pose integrator: sequencer with shared digit-serial multiplier,
// bit-serial divider and iterative CORDIC, plus pose state and registers.
// Depends on api_pkg.
//
// One word is taken at a time. The work is done by one shared multiplier
// that retires 4 bits of its second operand per cycle, one restoring
// divider that makes one quotient bit per cycle (five quotients on an arc
// tick) and one CORDIC rotation per cycle. A finished result waits in its
// own register, so the next word is taken while it waits.
// CORDIC_STAGES ranges from 8 to 24.
module ackermann_pose_integrator_unit import api_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [19:0]            req_dt_us,
   input  logic signed [23:0]     req_cmd_velocity,
   input  logic signed [23:0]     req_cmd_curvature,
   input  logic [23:0]            req_command_age_us,
   input  logic signed [15:0]     req_noise_bias,
   input  logic signed [15:0]     req_noise_arc,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_pos_x,
   output logic signed [31:0]     rsp_pos_y,
   output logic [15:0]            rsp_heading,
   output logic signed [21:0]     rsp_speed_out,
   output logic                   rsp_went_straight
);

   localparam int CNT_W = $clog2(CORDIC_STAGES);

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                   input int s);
      logic signed [63:0] t;
      t = v + (64'sd1 <<< (s - 1));
      return t >>> s;
   endfunction

   // configuration
   logic [20:0]        max_speed_ff;
   logic [19:0]        max_curv_ff;
   logic [21:0]        max_accel_ff;
   logic signed [17:0] bias_ff;
   logic [16:0]        aer_ff;
   logic [19:0]        stale_ff;

   // pose state
   logic signed [31:0] x_ff, y_ff;
   logic [15:0]        head_ff;
   logic signed [21:0] fv_ff;

   // sequencer
   state_type state_ff, state_in;
   logic      issued_ff;
   logic      mul_go, div_go, cor_go, unit_done, out_load;

   // word in flight
   logic [19:0]        dt_ff;
   logic signed [15:0] nb_ff, na_ff;
   logic signed [24:0] desired_ff, desired_in;
   logic signed [20:0] curv_ff, curv_in;
   logic               straight_ff, straight_in;
   logic signed [63:0] prod_ff;
   logic signed [23:0] dist_ff, bq_ff;
   logic signed [31:0] base_ff;
   logic signed [39:0] theta_ff;
   logic [31:0]        units_ff;
   logic signed [33:0] ca_ff, sa_ff;
   logic signed [31:0] ddx_ff, ddy_ff;
   logic signed [63:0] accx_ff, accy_ff;

   // result register
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic [15:0]        rsp_head_ff;
   logic signed [21:0] rsp_speed_ff;
   logic               rsp_straight_ff;

   // operand magnitudes
   logic [63:0] fv_mag, bias_mag, dist_mag, curv_mag, bq_mag, nb_mag, na_mag;
   logic [63:0] prod_mag, base_mag, theta_mag, ddx_mag, ddy_mag, ca_mag, sa_mag;

   assign fv_mag    = mag64(64'(fv_ff));
   assign bias_mag  = mag64(64'(bias_ff));
   assign dist_mag  = mag64(64'(dist_ff));
   assign curv_mag  = mag64(64'(curv_ff));
   assign bq_mag    = mag64(64'(bq_ff));
   assign nb_mag    = mag64(64'(nb_ff));
   assign na_mag    = mag64(64'(na_ff));
   assign prod_mag  = mag64(prod_ff);
   assign base_mag  = mag64(64'(base_ff));
   assign theta_mag = mag64(64'(theta_ff));
   assign ddx_mag   = mag64(64'(ddx_ff));
   assign ddy_mag   = mag64(64'(ddy_ff));
   assign ca_mag    = mag64(64'(ca_ff));
   assign sa_mag    = mag64(64'(sa_ff));

   // unit operands
   logic [63:0]        mul_op_a;
   logic [31:0]        mul_op_b;
   logic               mul_op_neg;
   logic signed [63:0] div_op_n;
   logic [19:0]        div_op_d;
   logic               div_op_dneg;
   logic [31:0]        cor_op_ang;
   logic               mul_start, div_start, cor_start;

   assign mul_start = mul_go && !issued_ff;
   assign div_start = div_go && !issued_ff;
   assign cor_start = cor_go && !issued_ff;

   // ---------------- multiplier: 4-bit digit of b per cycle ----------------
   logic        mul_busy_ff, mul_done_ff;
   logic [2:0]  mul_cnt_ff;
   logic [63:0] mul_a_ff, mul_acc_ff, mul_part;
   logic [31:0] mul_b_ff;
   logic        mul_neg_ff;
   logic signed [63:0] mul_res;

   always_comb begin
      mul_part = 64'd0;
      for (int k = 0; k < MUL_DIGIT; k++) begin
         if (mul_b_ff[k]) begin
            mul_part = mul_part + (mul_a_ff << k);
         end
      end
   end

   assign mul_res = mul_neg_ff ? -signed'(mul_acc_ff) : signed'(mul_acc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
         mul_done_ff <= 1'b0;
         mul_cnt_ff  <= '0;
      end else begin
         mul_done_ff <= 1'b0;
         if (mul_start) begin
            mul_busy_ff <= 1'b1;
            mul_cnt_ff  <= '0;
         end else if (mul_busy_ff) begin
            mul_cnt_ff <= mul_cnt_ff + 3'd1;
            if (mul_cnt_ff == 3'(MUL_STEPS - 1)) begin
               mul_busy_ff <= 1'b0;
               mul_done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_start) begin
         mul_a_ff   <= mul_op_a;
         mul_b_ff   <= mul_op_b;
         mul_neg_ff <= mul_op_neg;
         mul_acc_ff <= 64'd0;
      end else if (mul_busy_ff) begin
         mul_acc_ff <= mul_acc_ff + mul_part;
         mul_a_ff   <= mul_a_ff << MUL_DIGIT;
         mul_b_ff   <= mul_b_ff >> MUL_DIGIT;
      end
   end

   // ---------------- divider: one quotient bit per cycle ----------------
   logic                div_busy_ff, div_done_ff;
   logic [5:0]          div_cnt_ff;
   logic [DIV_BITS-1:0] div_num_ff;
   logic [19:0]         div_rem_ff, div_d_ff;
   logic                div_neg_ff;
   logic [20:0]         div_trial;
   logic                div_ge;
   logic [63:0]         div_n_mag;
   logic signed [47:0]  div_res;

   assign div_n_mag = mag64(div_op_n);
   assign div_trial = {div_rem_ff, div_num_ff[DIV_BITS-1]};
   assign div_ge    = div_trial >= {1'b0, div_d_ff};
   assign div_res   = div_neg_ff ? -signed'(48'(div_num_ff)) : signed'(48'(div_num_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else begin
         div_done_ff <= 1'b0;
         if (div_start) begin
            div_busy_ff <= 1'b1;
            div_cnt_ff  <= '0;
         end else if (div_busy_ff) begin
            div_cnt_ff <= div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'(DIV_BITS - 1)) begin
               div_busy_ff <= 1'b0;
               div_done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         div_num_ff <= div_n_mag[DIV_BITS-1:0] + DIV_BITS'(div_op_d >> 1);
         div_d_ff   <= div_op_d;
         div_rem_ff <= '0;
         div_neg_ff <= div_op_n[63] ^ div_op_dneg;
      end else if (div_busy_ff) begin
         div_rem_ff <= div_ge ? 20'(div_trial - {1'b0, div_d_ff}) : div_trial[19:0];
         div_num_ff <= {div_num_ff[DIV_BITS-2:0], div_ge};
      end
   end

   // ---------------- CORDIC: one rotation per cycle ----------------
   logic                     cor_busy_ff, cor_done_ff;
   logic [CNT_W-1:0]         cor_cnt_ff;
   logic signed [33:0]       cor_x_ff, cor_y_ff, cor_a_ff;
   logic                     cor_flip_ff;
   logic signed [33:0]       cor_a0, cor_a_fold, cor_dx, cor_dy, cor_at;
   logic                     cor_flip_in;
   logic signed [33:0]       cor_cos, cor_sin;

   always_comb begin
      cor_a0      = 34'(signed'(cor_op_ang));
      cor_a_fold  = cor_a0;
      cor_flip_in = 1'b0;
      if (cor_a0 > ONE_Q30) begin
         cor_a_fold  = cor_a0 - HALF_TURN;
         cor_flip_in = 1'b1;
      end else if (cor_a0 < -ONE_Q30) begin
         cor_a_fold  = cor_a0 + HALF_TURN;
         cor_flip_in = 1'b1;
      end
   end

   assign cor_dx  = cor_y_ff >>> cor_cnt_ff;
   assign cor_dy  = cor_x_ff >>> cor_cnt_ff;
   assign cor_at  = atan_lookup(5'(cor_cnt_ff));
   assign cor_cos = cor_flip_ff ? -cor_x_ff : cor_x_ff;
   assign cor_sin = cor_flip_ff ? -cor_y_ff : cor_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cor_busy_ff <= 1'b0;
         cor_done_ff <= 1'b0;
         cor_cnt_ff  <= '0;
      end else begin
         cor_done_ff <= 1'b0;
         if (cor_start) begin
            cor_busy_ff <= 1'b1;
            cor_cnt_ff  <= '0;
         end else if (cor_busy_ff) begin
            cor_cnt_ff <= cor_cnt_ff + CNT_W'(1);
            if (cor_cnt_ff == CNT_W'(CORDIC_STAGES - 1)) begin
               cor_busy_ff <= 1'b0;
               cor_done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cor_start) begin
         cor_x_ff    <= GAIN_Q30;
         cor_y_ff    <= '0;
         cor_a_ff    <= cor_a_fold;
         cor_flip_ff <= cor_flip_in;
      end else if (cor_busy_ff) begin
         if (!cor_a_ff[33]) begin
            cor_x_ff <= cor_x_ff - cor_dx;
            cor_y_ff <= cor_y_ff + cor_dy;
            cor_a_ff <= cor_a_ff - cor_at;
         end else begin
            cor_x_ff <= cor_x_ff + cor_dx;
            cor_y_ff <= cor_y_ff - cor_dy;
            cor_a_ff <= cor_a_ff + cor_at;
         end
      end
   end

   assign unit_done = mul_done_ff || div_done_ff || cor_done_ff;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_M_DV;
         ST_M_DV:   if (unit_done) state_in = ST_D_DV;
         ST_D_DV:   if (unit_done) state_in = ST_M_DIST;
         ST_M_DIST: if (unit_done) state_in = ST_D_DIST;
         ST_D_DIST: if (unit_done) state_in = ST_M_BIAS;
         ST_M_BIAS: if (unit_done) state_in = ST_D_BIAS;
         ST_D_BIAS: if (unit_done) state_in = straight_ff ? ST_M_BAM : ST_M_BASE;
         ST_M_BASE: if (unit_done) state_in = ST_M_NB;
         ST_M_NB:   if (unit_done) state_in = ST_M_NA;
         ST_M_NA:   if (unit_done) state_in = ST_M_NAM;
         ST_M_NAM:  if (unit_done) state_in = ST_M_BAM;
         ST_M_BAM:  if (unit_done) state_in = straight_ff ? ST_C_HEAD : ST_C_ARC;
         ST_C_ARC:  if (unit_done) state_in = ST_D_X;
         ST_D_X:    if (unit_done) state_in = ST_D_Y;
         ST_D_Y:    if (unit_done) state_in = ST_C_HEAD;
         ST_C_HEAD: if (unit_done) state_in = ST_M_XA;
         ST_M_XA:   if (unit_done) state_in = ST_M_XB;
         ST_M_XB:   if (unit_done) state_in = ST_M_YA;
         ST_M_YA:   if (unit_done) state_in = ST_M_YB;
         ST_M_YB:   if (unit_done) state_in = ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      out_load    = 1'b0;
      mul_go      = 1'b0;
      div_go      = 1'b0;
      cor_go      = 1'b0;
      mul_op_a    = '0;
      mul_op_b    = '0;
      mul_op_neg  = 1'b0;
      div_op_n    = prod_ff;
      div_op_d    = US_PER_S;
      div_op_dneg = 1'b0;
      cor_op_ang  = units_ff;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_M_DV: begin
            mul_go   = 1'b1;
            mul_op_a = 64'(dt_ff);
            mul_op_b = 32'(max_accel_ff);
         end
         ST_M_DIST: begin
            mul_go     = 1'b1;
            mul_op_a   = fv_mag;
            mul_op_b   = 32'(dt_ff);
            mul_op_neg = fv_ff[21];
         end
         ST_M_BIAS: begin
            mul_go     = 1'b1;
            mul_op_a   = bias_mag << 4;
            mul_op_b   = 32'(dt_ff);
            mul_op_neg = bias_ff[17];
         end
         ST_D_DV, ST_D_DIST, ST_D_BIAS: div_go = 1'b1;
         ST_M_BASE: begin
            mul_go     = 1'b1;
            mul_op_a   = dist_mag;
            mul_op_b   = curv_mag[31:0];
            mul_op_neg = dist_ff[23] ^ curv_ff[20];
         end
         ST_M_NB: begin
            mul_go     = 1'b1;
            mul_op_a   = bq_mag;
            mul_op_b   = nb_mag[31:0];
            mul_op_neg = bq_ff[23] ^ nb_ff[15];
         end
         ST_M_NA: begin
            mul_go     = 1'b1;
            mul_op_a   = 64'(aer_ff);
            mul_op_b   = na_mag[31:0];
            mul_op_neg = na_ff[15];
         end
         ST_M_NAM: begin
            mul_go     = 1'b1;
            mul_op_a   = base_mag;
            mul_op_b   = prod_mag[31:0];
            mul_op_neg = prod_ff[63];
         end
         ST_M_BAM: begin
            mul_go     = 1'b1;
            mul_op_a   = theta_mag;
            mul_op_b   = RAD_TO_BAM;
            mul_op_neg = theta_ff[39];
         end
         ST_C_ARC: cor_go = 1'b1;
         ST_D_X: begin
            div_go      = 1'b1;
            div_op_n    = 64'(sa_ff) <<< 2;
            div_op_d    = curv_mag[19:0];
            div_op_dneg = curv_ff[20];
         end
         ST_D_Y: begin
            div_go      = 1'b1;
            div_op_n    = (64'(ONE_Q30) - 64'(ca_ff)) <<< 2;
            div_op_d    = curv_mag[19:0];
            div_op_dneg = curv_ff[20];
         end
         ST_C_HEAD: begin
            cor_go     = 1'b1;
            cor_op_ang = {head_ff, 16'd0};
         end
         ST_M_XA: begin
            mul_go     = 1'b1;
            mul_op_a   = ddx_mag;
            mul_op_b   = ca_mag[31:0];
            mul_op_neg = ddx_ff[31] ^ ca_ff[33];
         end
         ST_M_XB: begin
            mul_go     = 1'b1;
            mul_op_a   = ddy_mag;
            mul_op_b   = sa_mag[31:0];
            mul_op_neg = ddy_ff[31] ^ sa_ff[33];
         end
         ST_M_YA: begin
            mul_go     = 1'b1;
            mul_op_a   = ddx_mag;
            mul_op_b   = sa_mag[31:0];
            mul_op_neg = ddx_ff[31] ^ sa_ff[33];
         end
         ST_M_YB: begin
            mul_go     = 1'b1;
            mul_op_a   = ddy_mag;
            mul_op_b   = ca_mag[31:0];
            mul_op_neg = ddy_ff[31] ^ ca_ff[33];
         end
         ST_DONE: out_load = !rsp_valid_ff || rsp_ready;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (unit_done) begin
            issued_ff <= 1'b0;
         end else if (mul_start || div_start || cor_start) begin
            issued_ff <= 1'b1;
         end
      end
   end

   // ---------------- command conditioning at acceptance ----------------
   logic signed [24:0] vsel, ms_pos, cin, mc_pos;

   always_comb begin
      vsel = (req_command_age_us > 24'(stale_ff)) ? 25'sd0 : 25'(req_cmd_velocity);
      if (fv_ff == 22'sd0 && vsel < STOP_LIMIT) begin
         vsel = 25'sd0;
      end
      ms_pos = signed'({4'd0, max_speed_ff});
      if (vsel > ms_pos) begin
         desired_in = ms_pos;
      end else if (vsel < -ms_pos) begin
         desired_in = -ms_pos;
      end else begin
         desired_in = vsel;
      end
      cin    = 25'(req_cmd_curvature);
      mc_pos = signed'({5'd0, max_curv_ff});
      if (cin > mc_pos) begin
         curv_in = mc_pos[20:0];
      end else if (cin < -mc_pos) begin
         curv_in = 21'(-mc_pos);
      end else begin
         curv_in = cin[20:0];
      end
      straight_in = (curv_in > -STRAIGHT_LIMIT) && (curv_in < STRAIGHT_LIMIT);
   end

   // ---------------- velocity update ----------------
   logic signed [27:0] vel_diff, vel_dvm, vel_dv, vel_sum;
   logic signed [21:0] vel_in;

   always_comb begin
      vel_diff = 28'(desired_ff) - 28'(fv_ff);
      vel_dvm  = signed'(div_res[27:0]);
      if (vel_diff > vel_dvm) begin
         vel_dv = vel_dvm;
      end else if (vel_diff < -vel_dvm) begin
         vel_dv = -vel_dvm;
      end else begin
         vel_dv = vel_diff;
      end
      vel_sum = 28'(fv_ff) + vel_dv;
      if (vel_sum > VEL_MAX) begin
         vel_in = VEL_MAX[21:0];
      end else if (vel_sum < VEL_MIN) begin
         vel_in = VEL_MIN[21:0];
      end else begin
         vel_in = vel_sum[21:0];
      end
   end

   // ---------------- pose update ----------------
   logic signed [63:0] rnd12, rnd28, wx64, wy64, bam_sum;
   logic signed [33:0] nx, ny;
   logic signed [31:0] x_in, y_in;
   logic [15:0]        head_in;

   assign rnd12   = shr_round(mul_res, 12);
   assign rnd28   = shr_round(mul_res, 28);
   assign bam_sum = mul_res + 64'sd524288;
   assign wx64    = shr_round(accx_ff, 30);
   assign wy64    = shr_round(accy_ff, 30);
   assign nx      = 34'(x_ff) + signed'(wx64[33:0]);
   assign ny      = 34'(y_ff) + signed'(wy64[33:0]);
   assign x_in    = (nx > POS_MAX) ? POS_MAX[31:0] : ((nx < POS_MIN) ? POS_MIN[31:0] : nx[31:0]);
   assign y_in    = (ny > POS_MAX) ? POS_MAX[31:0] : ((ny < POS_MIN) ? POS_MIN[31:0] : ny[31:0]);
   assign head_in = head_ff + units_ff[31:16] + 16'(units_ff[15]);

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         dt_ff       <= req_dt_us;
         nb_ff       <= req_noise_bias;
         na_ff       <= req_noise_arc;
         desired_ff  <= desired_in;
         curv_ff     <= curv_in;
         straight_ff <= straight_in;
      end
      if (unit_done) begin
         case (state_ff)
            ST_M_DV, ST_M_DIST, ST_M_BIAS, ST_M_NA: prod_ff <= mul_res;
            ST_D_DIST: dist_ff <= div_res[23:0];
            ST_D_BIAS: begin
               bq_ff <= div_res[23:0];
               if (straight_ff) begin
                  theta_ff <= div_res[39:0];
                  ddx_ff   <= 32'(dist_ff);
                  ddy_ff   <= '0;
               end
            end
            ST_M_BASE: begin
               base_ff  <= rnd12[31:0];
               theta_ff <= rnd12[39:0];
            end
            ST_M_NB:   theta_ff <= theta_ff + signed'(rnd12[39:0]);
            ST_M_NAM:  theta_ff <= theta_ff + signed'(rnd28[39:0]);
            ST_M_BAM:  units_ff <= bam_sum[51:20];
            ST_C_ARC, ST_C_HEAD: begin
               ca_ff <= cor_cos;
               sa_ff <= cor_sin;
            end
            ST_D_X:  ddx_ff <= div_res[31:0];
            ST_D_Y:  ddy_ff <= div_res[31:0];
            ST_M_XA: accx_ff <= mul_res;
            ST_M_XB: accx_ff <= accx_ff - mul_res;
            ST_M_YA: accy_ff <= mul_res;
            ST_M_YB: accy_ff <= accy_ff + mul_res;
            default: ;
         endcase
      end
      if (out_load) begin
         rsp_x_ff        <= x_in;
         rsp_y_ff        <= y_in;
         rsp_head_ff     <= head_in;
         rsp_speed_ff    <= fv_ff;
         rsp_straight_ff <= straight_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= RST_MAX_SPEED;
         max_curv_ff  <= RST_MAX_CURVATURE;
         max_accel_ff <= RST_MAX_ACCEL;
         bias_ff      <= '0;
         aer_ff       <= '0;
         stale_ff     <= RST_STALE_AGE;
         x_ff         <= '0;
         y_ff         <= '0;
         head_ff      <= '0;
         fv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MAX_SPEED:     max_speed_ff <= csr_wdata[20:0];
               CSR_MAX_CURVATURE: max_curv_ff  <= csr_wdata[19:0];
               CSR_MAX_ACCEL:     max_accel_ff <= csr_wdata[21:0];
               CSR_ANGULAR_BIAS:  bias_ff      <= csr_wdata[17:0];
               CSR_ANGULAR_ERROR: aer_ff       <= csr_wdata[16:0];
               CSR_STALE_AGE:     stale_ff     <= csr_wdata[19:0];
               default: ;
            endcase
         end
         if (state_ff == ST_D_DV && unit_done) begin
            fv_ff <= vel_in;
         end
         if (out_load) begin
            x_ff         <= x_in;
            y_ff         <= y_in;
            head_ff      <= head_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = rsp_x_ff;
   assign rsp_pos_y         = rsp_y_ff;
   assign rsp_heading       = rsp_head_ff;
   assign rsp_speed_out     = rsp_speed_ff;
   assign rsp_went_straight = rsp_straight_ff;

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_busy_ff, div_busy_ff, cor_busy_ff}))
      else $error("more than one arithmetic unit busy");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(mul_busy_ff || div_busy_ff || cor_busy_ff))
      else $error("unit busy while idle");

   assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("result load lost");

   assert property (@(posedge clock) disable iff (reset)
      unit_done |-> !issued_ff == 1'b0)
      else $error("unit finished without an issued operation");

endmodule
